FILE: src/c8x_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared types, constants and the font table for the CHIP-8 execute unit.
// ----------------------------------------------------------------------------
package c8x_pkg;

    localparam int MEM_BYTES     = 4096;
    localparam int MEM_AW        = $clog2(MEM_BYTES);
    localparam int PROGRAM_START = 512;
    localparam int STACK_DEPTH   = 16;
    localparam int SAW           = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SLW           = $clog2(STACK_DEPTH + 1);
    localparam int GLYPH_ROWS    = 5;
    localparam int FONT_BYTES    = 16 * GLYPH_ROWS;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNKNOWN   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW = 2'd3;

    localparam logic OP_EXEC  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [15:0] OPC_CLS = 16'h00E0;
    localparam logic [15:0] OPC_RET = 16'h00EE;
    localparam logic [7:0]  KK_SKP  = 8'h9E;
    localparam logic [7:0]  KK_SKNP = 8'hA1;
    localparam logic [7:0]  KK_LDVD = 8'h07;
    localparam logic [7:0]  KK_LDK  = 8'h0A;
    localparam logic [7:0]  KK_LDDT = 8'h15;
    localparam logic [7:0]  KK_LDST = 8'h18;
    localparam logic [7:0]  KK_ADDI = 8'h1E;
    localparam logic [7:0]  KK_FONT = 8'h29;
    localparam logic [7:0]  KK_BCD  = 8'h33;
    localparam logic [7:0]  KK_STOR = 8'h55;
    localparam logic [7:0]  KK_LOAD = 8'h65;

    typedef struct packed {
        logic        operation;
        logic [15:0] opcode;
        logic [11:0] mem_address;
        logic [7:0]  mem_data;
        logic [15:0] keys_down;
        logic [3:0]  awaited_key;
        logic [7:0]  random_byte;
    } in_word_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [15:0] index_value;
        logic [7:0]  flag_value;
        logic [7:0]  delay_value;
        logic [7:0]  sound_value;
        logic        clear_request;
        logic        draw_request;
        logic [7:0]  draw_x;
        logic [7:0]  draw_y;
        logic [3:0]  draw_rows;
        logic [1:0]  status;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_RDX,
        S_RDY,
        S_EXEC,
        S_BCD,
        S_STR,
        S_STW,
        S_LDR,
        S_LDW,
        S_RDF,
        S_DONE
    } state_t;

    typedef struct packed {
        logic            we;
        logic [3:0]      waddr;
        logic [7:0]      wdata;
        logic [3:0]      raddr;
    } reg_ctl_t;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        wdata;
    } mem_ctl_t;

    function automatic logic [7:0] font_byte(input logic [6:0] a);
        logic [7:0] f [0:FONT_BYTES-1];
        f = '{8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
              8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
              8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
              8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
              8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
              8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
              8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
              8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80};
        if (a < 7'(FONT_BYTES))
            font_byte = f[a];
        else
            font_byte = 8'h00;
    endfunction

endpackage
`default_nettype wire

FILE: src/chip8_instruction_execute_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_instruction_execute_unit
// CHIP-8 execute unit with memory, registers, stack and timers.
// ----------------------------------------------------------------------------
// After reset the unit loads the font and clears main memory and accepts no
// word until then. Words are then handled one at a time: a byte write is
// written directly; an opcode reads Vx, Vy and V0 in turn through the single
// register file port, and BCD and Fx55/Fx65 move bytes one by one through
// the single main memory port. The result word is held until taken.
module chip8_instruction_execute_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire c8x_pkg::in_word_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output c8x_pkg::out_word_t      out_data
);

    localparam int AW = c8x_pkg::MEM_AW;

    c8x_pkg::state_t   st_reg, st_next;
    c8x_pkg::in_word_t iw_reg;
    c8x_pkg::reg_ctl_t rctl;
    c8x_pkg::mem_ctl_t mctl;
    logic [7:0]        rdata, mdata, vx_reg, vy_reg, v0_reg;
    logic [15:0]       sdata;
    logic [AW-1:0]     cnt_reg;
    logic [15:0]       pc_reg, idx_reg;
    logic [15:0]       pc_ret;
    logic [7:0]        vf_reg, dt_reg, snd_reg;
    logic [c8x_pkg::SLW-1:0] sl_reg;
    logic              s_we;
    logic [c8x_pkg::SAW-1:0] s_addr;
    logic [1:0]        bcd_reg;
    logic [7:0]        hund, tens, ones;
    c8x_pkg::out_word_t res_reg;
    logic              ret_pend_reg;

    logic [3:0]  op_h, op_x, op_y, op_n;
    logic [7:0]  op_kk;
    logic [11:0] op_nnn;

    assign op_h   = iw_reg.opcode[15:12];
    assign op_x   = iw_reg.opcode[11:8];
    assign op_y   = iw_reg.opcode[7:4];
    assign op_n   = iw_reg.opcode[3:0];
    assign op_kk  = iw_reg.opcode[7:0];
    assign op_nnn = iw_reg.opcode[11:0];

    assign pc_ret = pc_reg + 16'd2;

    c8x_regfile u_rf (.clk(clk), .rst_n(rst_n), .ctl(rctl), .rdata(rdata));
    c8x_mainmem u_mm (.clk(clk), .ctl(mctl), .rdata(mdata));
    c8x_stack   u_st (.clk(clk), .we(s_we), .addr(s_addr), .wdata(pc_ret),
                      .rdata(sdata));

    assign hund = (vx_reg >= 8'd200) ? 8'd2 : (vx_reg >= 8'd100) ? 8'd1 : 8'd0;
    always_comb
    begin
        logic [7:0] r;
        r    = vx_reg - 8'(hund * 8'd100);
        tens = 8'(({8'h00, r} * 16'd205) >> 11);
        ones = r - 8'(tens * 8'd10);
    end

    // Exec: compute results from vx_reg/vy_reg (registered reads).
    logic [7:0]  ex_val;
    logic        ex_we, ex_fwe, skip, unk;
    logic [7:0]  ex_flag;
    logic [8:0]  sum;

    always_comb
    begin
        ex_val  = 8'h00;
        ex_we   = 1'b0;
        ex_fwe  = 1'b0;
        ex_flag = 8'h00;
        skip    = 1'b0;
        unk     = 1'b0;
        sum     = {1'b0, vx_reg} + {1'b0, vy_reg};
        case (op_h)
            4'h0: unk = (iw_reg.opcode != c8x_pkg::OPC_CLS) &&
                        (iw_reg.opcode != c8x_pkg::OPC_RET);
            4'h3: skip = (vx_reg == op_kk);
            4'h4: skip = (vx_reg != op_kk);
            4'h5: begin unk = (op_n != 4'h0); skip = !unk && (vx_reg == vy_reg); end
            4'h9: begin unk = (op_n != 4'h0); skip = !unk && (vx_reg != vy_reg); end
            4'h6: begin ex_we = 1'b1; ex_val = op_kk; end
            4'h7: begin ex_we = 1'b1; ex_val = vx_reg + op_kk; end
            4'hC: begin ex_we = 1'b1; ex_val = iw_reg.random_byte & op_kk; end
            4'h8:
            begin
                ex_we = 1'b1;
                case (op_n)
                    4'h0: ex_val = vy_reg;
                    4'h1: ex_val = vx_reg | vy_reg;
                    4'h2: ex_val = vx_reg & vy_reg;
                    4'h3: ex_val = vx_reg ^ vy_reg;
                    4'h4: begin ex_val = sum[7:0]; ex_fwe = 1'b1;
                                ex_flag = {7'd0, sum[8]}; end
                    4'h5: begin ex_val = vx_reg - vy_reg; ex_fwe = 1'b1;
                                ex_flag = {7'd0, vx_reg >= vy_reg}; end
                    4'h6: begin ex_val = vx_reg >> 1; ex_fwe = 1'b1;
                                ex_flag = {7'd0, vx_reg[0]}; end
                    4'h7: begin ex_val = vy_reg - vx_reg; ex_fwe = 1'b1;
                                ex_flag = {7'd0, vy_reg >= vx_reg}; end
                    4'hE: begin ex_val = {vx_reg[6:0], 1'b0}; ex_fwe = 1'b1;
                                ex_flag = {7'd0, vx_reg[7]}; end
                    default: begin ex_we = 1'b0; unk = 1'b1; end
                endcase
            end
            4'hE:
            begin
                if (op_kk == c8x_pkg::KK_SKP)
                    skip = (vx_reg[7:4] == 4'h0) && iw_reg.keys_down[vx_reg[3:0]];
                else if (op_kk == c8x_pkg::KK_SKNP)
                    skip = !((vx_reg[7:4] == 4'h0) && iw_reg.keys_down[vx_reg[3:0]]);
                else
                    unk = 1'b1;
            end
            4'hF:
            begin
                case (op_kk)
                    c8x_pkg::KK_LDVD: begin ex_we = 1'b1; ex_val = dt_reg; end
                    c8x_pkg::KK_LDK:  begin ex_we = 1'b1;
                                            ex_val = {4'h0, iw_reg.awaited_key}; end
                    c8x_pkg::KK_LDDT, c8x_pkg::KK_LDST, c8x_pkg::KK_ADDI,
                    c8x_pkg::KK_FONT, c8x_pkg::KK_BCD, c8x_pkg::KK_STOR,
                    c8x_pkg::KK_LOAD: ;
                    default: unk = 1'b1;
                endcase
            end
            default: ;
        endcase
    end

    logic [AW-1:0] ioff;
    assign ioff = idx_reg[AW-1:0] + AW'(cnt_reg);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            c8x_pkg::S_INIT: if (cnt_reg == AW'(c8x_pkg::MEM_BYTES - 1))
                                 st_next = c8x_pkg::S_IDLE;
            c8x_pkg::S_IDLE:
                if (in_valid && in_ready)
                    st_next = (in_data.operation == c8x_pkg::OP_WRITE)
                              ? c8x_pkg::S_DONE : c8x_pkg::S_RDX;
            c8x_pkg::S_RDX: st_next = c8x_pkg::S_RDY;
            c8x_pkg::S_RDY: st_next = c8x_pkg::S_RDF;
            c8x_pkg::S_RDF: st_next = c8x_pkg::S_EXEC;
            c8x_pkg::S_EXEC:
                if (op_h == 4'hF && op_kk == c8x_pkg::KK_BCD)
                    st_next = c8x_pkg::S_BCD;
                else if (op_h == 4'hF && op_kk == c8x_pkg::KK_STOR)
                    st_next = c8x_pkg::S_STR;
                else if (op_h == 4'hF && op_kk == c8x_pkg::KK_LOAD)
                    st_next = c8x_pkg::S_LDR;
                else
                    st_next = c8x_pkg::S_DONE;
            c8x_pkg::S_BCD: if (bcd_reg == 2'd2) st_next = c8x_pkg::S_DONE;
            c8x_pkg::S_STR: st_next = c8x_pkg::S_STW;
            c8x_pkg::S_STW: st_next = (cnt_reg[3:0] == op_x) ? c8x_pkg::S_DONE
                                                           : c8x_pkg::S_STR;
            c8x_pkg::S_LDR: st_next = c8x_pkg::S_LDW;
            c8x_pkg::S_LDW: st_next = (cnt_reg[3:0] == op_x) ? c8x_pkg::S_DONE
                                                           : c8x_pkg::S_LDR;
            c8x_pkg::S_DONE: if (out_ready && !ret_pend_reg) st_next = c8x_pkg::S_IDLE;
            default: st_next = c8x_pkg::S_IDLE;
        endcase
    end

    function automatic logic [c8x_pkg::SAW-1:0] SAW_M1(input logic [c8x_pkg::SLW-1:0] v);
        logic [c8x_pkg::SLW-1:0] t;
        t = v - c8x_pkg::SLW'(1);
        SAW_M1 = t[c8x_pkg::SAW-1:0];
    endfunction

    always_comb
    begin
        rctl  = '0;
        mctl  = '0;
        s_we  = 1'b0;
        s_addr = sl_reg[c8x_pkg::SAW-1:0];
        case (st_reg)
            c8x_pkg::S_INIT:
            begin
                mctl.we    = 1'b1;
                mctl.addr  = cnt_reg;
                mctl.wdata = c8x_pkg::font_byte(7'(cnt_reg[6:0])) &
                             {8{cnt_reg[AW-1:7] == '0}};
            end
            c8x_pkg::S_IDLE:
            begin
                mctl.we    = in_valid && in_data.operation == c8x_pkg::OP_WRITE;
                mctl.addr  = in_data.mem_address;
                mctl.wdata = in_data.mem_data;
                rctl.raddr = in_data.opcode[11:8];
            end
            c8x_pkg::S_RDX: rctl.raddr = op_y;
            c8x_pkg::S_RDY: rctl.raddr = 4'h0;
            c8x_pkg::S_RDF:
            begin
                rctl.raddr = 4'hF;
                s_addr = SAW_M1(sl_reg);
            end
            c8x_pkg::S_EXEC:
            begin
                rctl.we    = ex_we;
                rctl.waddr = op_x;
                rctl.wdata = ex_val;
                s_we = (op_h == 4'h2) && (sl_reg < c8x_pkg::SLW'(c8x_pkg::STACK_DEPTH));
            end
            c8x_pkg::S_BCD:
            begin
                mctl.we    = 1'b1;
                mctl.addr  = idx_reg[AW-1:0] + AW'(bcd_reg);
                mctl.wdata = (bcd_reg == 2'd0) ? hund : (bcd_reg == 2'd1) ? tens : ones;
            end
            c8x_pkg::S_STR: rctl.raddr = cnt_reg[3:0];
            c8x_pkg::S_STW:
            begin
                mctl.we    = 1'b1;
                mctl.addr  = ioff;
                mctl.wdata = (cnt_reg[3:0] == 4'hF) ? vf_reg : rdata;
                rctl.raddr = 4'hF;
            end
            c8x_pkg::S_LDR: mctl.addr = ioff;
            c8x_pkg::S_LDW:
            begin
                rctl.we    = 1'b1;
                rctl.waddr = cnt_reg[3:0];
                rctl.wdata = mdata;
            end
            default: ;
        endcase
    end

    assign in_ready  = (st_reg == c8x_pkg::S_IDLE);
    assign out_valid = (st_reg == c8x_pkg::S_DONE) && !ret_pend_reg;
    assign out_data  = res_reg;

    always_ff @(posedge clk)
    begin
        if (st_reg == c8x_pkg::S_IDLE && in_valid)
            iw_reg <= in_data;
        if (st_reg == c8x_pkg::S_RDX) vx_reg <= (op_x == 4'hF) ? vf_reg : rdata;
        if (st_reg == c8x_pkg::S_RDY) vy_reg <= (op_y == 4'hF) ? vf_reg : rdata;
        if (st_reg == c8x_pkg::S_RDF) v0_reg <= rdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= c8x_pkg::S_INIT;
            cnt_reg  <= '0;
            pc_reg   <= 16'(c8x_pkg::PROGRAM_START);
            idx_reg  <= '0;
            vf_reg   <= '0;
            dt_reg   <= '0;
            snd_reg  <= '0;
            sl_reg   <= '0;
            bcd_reg  <= '0;
            res_reg  <= '0;
            ret_pend_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            case (st_reg)
                c8x_pkg::S_INIT:
                    cnt_reg <= cnt_reg + AW'(1);
                c8x_pkg::S_IDLE:
                begin
                    c8x_pkg::out_word_t rw;
                    cnt_reg <= '0;
                    bcd_reg <= '0;
                    if (in_valid && in_data.operation == c8x_pkg::OP_WRITE)
                    begin
                        rw = '0;
                        rw.next_pc     = pc_reg;
                        rw.index_value = idx_reg;
                        rw.flag_value  = vf_reg;
                        rw.delay_value = dt_reg;
                        rw.sound_value = snd_reg;
                        rw.status      = c8x_pkg::ST_OK;
                        res_reg <= rw;
                    end
                end
                c8x_pkg::S_EXEC:
                begin
                    logic [15:0] pc2, pcn;
                    logic [1:0]  stv;
                    c8x_pkg::out_word_t rw;
                    pc2 = pc_reg + 16'd2;
                    pcn = skip ? pc_reg + 16'd4 : pc2;
                    stv = unk ? c8x_pkg::ST_UNKNOWN : c8x_pkg::ST_OK;
                    case (op_h)
                        4'h0:
                            if (iw_reg.opcode == c8x_pkg::OPC_RET)
                            begin
                                if (sl_reg == '0) stv = c8x_pkg::ST_UNDERFLOW;
                                else begin
                                    sl_reg <= sl_reg - c8x_pkg::SLW'(1);
                                    pcn = sdata;
                                end
                            end
                        4'h1: pcn = {4'h0, op_nnn};
                        4'h2:
                            if (sl_reg >= c8x_pkg::SLW'(c8x_pkg::STACK_DEPTH))
                                stv = c8x_pkg::ST_OVERFLOW;
                            else begin
                                sl_reg <= sl_reg + c8x_pkg::SLW'(1);
                                pcn = {4'h0, op_nnn};
                            end
                        4'hA: idx_reg <= {4'h0, op_nnn};
                        4'hB: pcn = {4'h0, op_nnn} + {8'h00, v0_reg};
                        4'hF:
                            case (op_kk)
                                c8x_pkg::KK_LDDT: dt_reg <= vx_reg;
                                c8x_pkg::KK_LDST: snd_reg <= vx_reg;
                                c8x_pkg::KK_ADDI: idx_reg <= idx_reg + {8'h00, vx_reg};
                                c8x_pkg::KK_FONT: idx_reg <= {12'h000, vx_reg[3:0]} *
                                                             16'(c8x_pkg::GLYPH_ROWS);
                                default: ;
                            endcase
                        default: ;
                    endcase
                    pc_reg <= pcn;
                    if (ex_fwe) vf_reg <= ex_flag;
                    else if (ex_we && op_x == 4'hF) vf_reg <= ex_val;
                    rw = '0;
                    rw.status = stv;
                    rw.clear_request = (iw_reg.opcode == c8x_pkg::OPC_CLS);
                    if (op_h == 4'hD)
                    begin
                        rw.draw_request = 1'b1;
                        rw.draw_x = vx_reg;
                        rw.draw_y = vy_reg;
                        rw.draw_rows = op_n;
                    end
                    res_reg <= rw;
                    ret_pend_reg <= 1'b1;
                end
                c8x_pkg::S_BCD: bcd_reg <= bcd_reg + 2'd1;
                c8x_pkg::S_STW: cnt_reg <= cnt_reg + AW'(1);
                c8x_pkg::S_LDW:
                begin
                    cnt_reg <= cnt_reg + AW'(1);
                    if (cnt_reg[3:0] == 4'hF) vf_reg <= mdata;
                end
                c8x_pkg::S_DONE:
                begin
                    c8x_pkg::out_word_t rw;
                    if (ret_pend_reg)
                    begin
                        rw = res_reg;
                        rw.next_pc     = pc_reg;
                        rw.index_value = idx_reg;
                        rw.flag_value  = vf_reg;
                        rw.delay_value = dt_reg;
                        rw.sound_value = snd_reg;
                        res_reg <= rw;
                        ret_pend_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: src/c8x_regfile.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_regfile
// Sixteen byte registers V0..VF in a one-port-read synchronous memory with
// a valid bit per entry so that reset reads as zero.
// ----------------------------------------------------------------------------
module c8x_regfile (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire c8x_pkg::reg_ctl_t  ctl,
    output logic [7:0]              rdata
);

    logic [7:0]  mem [0:15];
    logic [15:0] vld_reg;
    logic [7:0]  rd_reg;
    logic        rv_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        rd_reg <= mem[ctl.raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            rv_reg  <= 1'b0;
        end
        else
        begin
            rv_reg <= vld_reg[ctl.raddr];
            if (ctl.we)
            begin
                vld_reg[ctl.waddr] <= 1'b1;
            end
        end
    end

    assign rdata = rv_reg ? rd_reg : 8'h00;

endmodule
`default_nettype wire

FILE: src/c8x_mainmem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_mainmem
// 4 KiB main memory, one port, registered read. The font is loaded by a
// clearing pass driven from the sequencer.
// ----------------------------------------------------------------------------
module c8x_mainmem (
    input  wire logic               clk,
    input  wire c8x_pkg::mem_ctl_t  ctl,
    output logic [7:0]              rdata
);

    logic [7:0] mem [0:c8x_pkg::MEM_BYTES-1];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.addr] <= ctl.wdata;
        end
        rdata <= mem[ctl.addr];
    end

endmodule
`default_nettype wire

FILE: src/c8x_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_stack
// Return stack memory with registered read.
// ----------------------------------------------------------------------------
module c8x_stack (
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [c8x_pkg::SAW-1:0] addr,
    input  wire logic [15:0]            wdata,
    output logic [15:0]                 rdata
);

    logic [15:0] mem [0:c8x_pkg::STACK_DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire
